// ----- rtl/dos_pkg.sv -----
// package: types and constants of the deadline order scheduler
`default_nettype none
package dos_pkg;

  localparam int unsigned MaxOrdersDefault  = 64;
  localparam int unsigned NumOpTypesDefault = 16;
  localparam int unsigned TimeW             = 24;
  localparam int unsigned DivSteps          = 16;

  // command codes
  localparam logic [1:0] CMD_ORDER = 2'd0;
  localparam logic [1:0] CMD_RATE  = 2'd1;
  localparam logic [1:0] CMD_SETUP = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  op_type;
    logic [3:0]  next_op;
    logic [15:0] value;
    logic [15:0] order_id;
    logic [15:0] deadline;
    logic        last_order;
  } in_item_t;

  typedef struct packed {
    logic [23:0] start_time;
    logic [3:0]  order_type;
    logic [15:0] order_number;
    logic [15:0] work_amount;
    logic        final_res;
    logic        rate_missing;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] work;
    logic [3:0]  op;
    logic [15:0] deadline;
  } order_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_EMIT  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_SETUP = 6'b010000,
    ST_SADD  = 6'b100000
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/deadline_order_scheduler.sv -----
// top level: order loading, deadline sort by repeated scans and schedule walk
`default_nettype none
// Rate and setup entries, and orders that are not last, are taken while idle.
// An order marked last starts a run over the n stored orders, during which no
// item is taken: each of the n results needs one scan over the order memory
// (one read a cycle) to find the next order by (deadline, arrival), the
// ST_EMIT state to issue the result, which waits while the output is stalled,
// the bit-serial divider when the rate is present, and the ST_SETUP and ST_SADD
// states for the setup memory read before all but the first result. The setup
// table sits in a memory with a valid bit per entry.
module deadline_order_scheduler import dos_pkg::*; #(
  parameter int unsigned MAX_ORDERS   = MaxOrdersDefault,
  parameter int unsigned NUM_OP_TYPES = NumOpTypesDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_item_t  out_data_o
);

  localparam int unsigned IW  = $clog2(MAX_ORDERS);
  localparam int unsigned CW  = $clog2(MAX_ORDERS + 1);
  localparam int unsigned TW  = $clog2(NUM_OP_TYPES);
  localparam int unsigned SD  = NUM_OP_TYPES * NUM_OP_TYPES;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned KW  = 16 + IW;

  state_e state_q;

  // order memory
  order_t          ord_mem [MAX_ORDERS];
  order_t          rd_data_q;
  logic   [IW-1:0] rd_idx_q;
  logic            rd_v_q;
  logic   [CW-1:0] iss_q;
  logic   [CW-1:0] cnt_q, n_q, pos_q;

  // rate table and setup memory
  logic [15:0]   rate_q  [NUM_OP_TYPES];
  logic [15:0]   setup_mem [SD];
  logic [SD-1:0] setup_vld_q;
  logic [15:0]   setup_rd_q;
  logic          setup_hit_q;

  // current order, previous key and schedule time
  order_t          best_q;
  logic   [IW-1:0] best_idx_q;
  logic            best_valid_q;
  logic   [KW-1:0] prev_key_q;
  logic            have_prev_q;
  logic   [3:0]    prev_op_q;
  logic   [TimeW-1:0] elapsed_q;

  // divider
  logic [15:0] quo_q;
  logic [16:0] rem_q;
  logic [3:0]  div_cnt_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic in_acc;
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // rate lookup for the current order
  logic [15:0] cur_rate;
  logic        cur_missing;
  always_comb begin
    cur_rate = 16'd0;
    if (32'(best_q.op) < NUM_OP_TYPES) begin
      cur_rate = rate_q[best_q.op[TW-1:0]];
    end
    cur_missing = (cur_rate == 16'd0);
  end

  // scan compare
  logic [KW-1:0] cand_key, best_key;
  logic          take, scan_last, issue;
  always_comb begin
    cand_key  = {rd_data_q.deadline, rd_idx_q};
    best_key  = {best_q.deadline, best_idx_q};
    take      = rd_v_q && (!have_prev_q || cand_key > prev_key_q) &&
                (!best_valid_q || cand_key < best_key);
    scan_last = rd_v_q && (CW'(rd_idx_q) == n_q - CW'(1));
    issue     = (state_q == ST_SCAN) && (iss_q < n_q);
  end

  // divider step
  logic [16:0] rem_sh, rem_n;
  logic [15:0] quo_n;
  logic [16:0] dur;
  always_comb begin
    rem_sh = {rem_q[15:0], quo_q[15]};
    quo_n  = {quo_q[14:0], 1'b0};
    rem_n  = rem_sh;
    if (rem_sh >= {1'b0, cur_rate}) begin
      rem_n    = rem_sh - {1'b0, cur_rate};
      quo_n[0] = 1'b1;
    end
    dur = {1'b0, quo_n} + {16'd0, (rem_n != 17'd0)};
  end

  // setup address for the pair of types
  logic [SAW-1:0] setup_addr;
  logic           setup_in_rng;
  always_comb begin
    setup_in_rng = (32'(prev_op_q) < NUM_OP_TYPES) && (32'(best_q.op) < NUM_OP_TYPES);
    setup_addr   = SAW'(32'(prev_op_q) * NUM_OP_TYPES + 32'(best_q.op));
  end

  logic [SAW-1:0] wr_setup_addr;
  logic           wr_setup;
  always_comb begin
    wr_setup_addr = SAW'(32'(in_data_i.op_type) * NUM_OP_TYPES + 32'(in_data_i.next_op));
    wr_setup = in_acc && (in_data_i.command == CMD_SETUP) &&
               (32'(in_data_i.op_type) < NUM_OP_TYPES) &&
               (32'(in_data_i.next_op) < NUM_OP_TYPES);
  end

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [16:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + (TimeW+1)'(b);
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  // order memory write and scan read
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.command == CMD_ORDER) && (cnt_q < CW'(MAX_ORDERS))) begin
      ord_mem[cnt_q[IW-1:0]] <= '{id: in_data_i.order_id, work: in_data_i.value,
                                  op: in_data_i.op_type, deadline: in_data_i.deadline};
    end
    rd_data_q <= ord_mem[iss_q[IW-1:0]];
  end

  // setup memory write and read
  always_ff @(posedge clk_i) begin
    if (wr_setup) begin
      setup_mem[wr_setup_addr] <= in_data_i.value;
    end
    setup_rd_q <= setup_mem[setup_addr];
  end

  // control, tables and schedule walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      n_q          <= '0;
      pos_q        <= '0;
      iss_q        <= '0;
      rd_v_q       <= 1'b0;
      rd_idx_q     <= '0;
      setup_vld_q  <= '0;
      setup_hit_q  <= 1'b0;
      best_valid_q <= 1'b0;
      have_prev_q  <= 1'b0;
      elapsed_q    <= '0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
      for (int i = 0; i < NUM_OP_TYPES; i++) begin
        rate_q[i] <= 16'd0;
      end
    end else begin
      rd_v_q   <= issue;
      rd_idx_q <= iss_q[IW-1:0];
      // a taken result leaves the register unless a new one is issued
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_data_i.command == CMD_RATE) &&
              (32'(in_data_i.op_type) < NUM_OP_TYPES)) begin
            rate_q[in_data_i.op_type[TW-1:0]] <= in_data_i.value;
          end
          if (wr_setup) begin
            setup_vld_q[wr_setup_addr] <= 1'b1;
          end
          if (in_acc && (in_data_i.command == CMD_ORDER)) begin
            if (in_data_i.last_order) begin
              n_q          <= (cnt_q < CW'(MAX_ORDERS)) ? cnt_q + CW'(1) : cnt_q;
              cnt_q        <= '0;
              pos_q        <= '0;
              iss_q        <= '0;
              elapsed_q    <= '0;
              have_prev_q  <= 1'b0;
              best_valid_q <= 1'b0;
              state_q      <= ST_SCAN;
            end else if (cnt_q < CW'(MAX_ORDERS)) begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            iss_q <= iss_q + CW'(1);
          end
          if (take) begin
            best_q       <= rd_data_q;
            best_idx_q   <= rd_idx_q;
            best_valid_q <= 1'b1;
          end
          if (scan_last) begin
            state_q <= (pos_q == '0) ? ST_EMIT : ST_SETUP;
          end
        end
        ST_SETUP: begin
          setup_hit_q <= setup_vld_q[setup_addr] && setup_in_rng;
          state_q     <= ST_SADD;
        end
        ST_SADD: begin
          if (setup_hit_q) begin
            elapsed_q <= sat_add(elapsed_q, {1'b0, setup_rd_q});
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_q <= '{start_time: elapsed_q, order_type: best_q.op,
                       order_number: best_q.id, work_amount: best_q.work,
                       final_res: (pos_q == n_q - CW'(1)), rate_missing: cur_missing};
            quo_q     <= best_q.work;
            rem_q     <= '0;
            div_cnt_q <= '0;
            if (!cur_missing) begin
              state_q <= ST_DIV;
            end else if (pos_q == n_q - CW'(1)) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q        <= pos_q + CW'(1);
              prev_op_q    <= best_q.op;
              prev_key_q   <= best_key;
              have_prev_q  <= 1'b1;
              best_valid_q <= 1'b0;
              iss_q        <= '0;
              state_q      <= ST_SCAN;
            end
          end
        end
        ST_DIV: begin
          quo_q     <= quo_n;
          rem_q     <= rem_n;
          div_cnt_q <= div_cnt_q + 4'd1;
          if (div_cnt_q == 4'(DivSteps - 1)) begin
            elapsed_q <= sat_add(elapsed_q, dur);
            if (pos_q == n_q - CW'(1)) begin
              state_q <= ST_IDLE;
            end else begin
              pos_q        <= pos_q + CW'(1);
              prev_op_q    <= best_q.op;
              prev_key_q   <= best_key;
              have_prev_q  <= 1'b1;
              best_valid_q <= 1'b0;
              iss_q        <= '0;
              state_q      <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the divider only runs for an order whose rate is present
  a_div_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !cur_missing)
    else $error("divider running with missing rate");

  // a result is issued only for an order found by the scan
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> best_valid_q)
    else $error("result issued without a selected order");

  // the store never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CW'(MAX_ORDERS)) && (n_q <= CW'(MAX_ORDERS)))
    else $error("order count beyond store depth");

endmodule
`default_nettype wire
